[rtl/pnmp_pkg.sv]
// pnmp_pkg: shared types, codes and character constants for the pitch name parser
// used by every module under rtl; depends on nothing
package pnmp_pkg;

    // default widths of the saturating counters
    localparam int OFFSET_WIDTH_DEF = 12;
    localparam int OCTAVE_WIDTH_DEF = 10;

    // queue depth between the parts
    localparam int QUEUE_DEPTH = 2;

    // result field widths
    localparam int MIDI_WIDTH   = 7;
    localparam int STATUS_WIDTH = 3;

    // result arithmetic constants
    localparam int MIDI_CENTER = 60;
    localparam int MIDI_TOP    = 127;

    // characters the grammar cares about
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_FLAT  = 8'h62;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_C  = 8'h43;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_G  = 8'h47;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LETTER = 3'd1,
        ST_MIXED      = 3'd2,
        ST_BAD_OCTAVE = 3'd3,
        ST_RANGE      = 3'd4,
        ST_EMPTY      = 3'd5
    } status_t;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_LETTER = 5'b00001,
        PH_ACC    = 5'b00010,
        PH_SIGN   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    // classified character as it travels from front to back
    typedef struct packed {
        logic       last;
        logic       none;
        logic       is_letter;
        logic [3:0] pitch;
        logic       is_sharp;
        logic       is_flat;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } char_class_t;

endpackage

[rtl/pnmp_front.sv]
// pnmp_front: classifies one incoming character into a char_class_t record
// depends on pnmp_pkg
module pnmp_front (
    input  logic [7:0]            ch,
    input  logic                  last,
    input  logic                  no_char,
    output pnmp_pkg::char_class_t cls,
    output logic                  keep
);

    logic [7:0] upper;
    logic [7:0] digit_diff;

    // fold lower case letters to upper case
    always_comb
    begin
        if (ch >= pnmp_pkg::CH_LOW_A && ch <= pnmp_pkg::CH_LOW_Z)
        begin
            upper = ch - pnmp_pkg::CASE_GAP;
        end
        else
        begin
            upper = ch;
        end
    end

    assign digit_diff = ch - pnmp_pkg::CH_ZERO;

    // character classes
    always_comb
    begin
        cls           = '0;
        cls.last      = last;
        cls.none      = no_char;
        cls.is_sharp  = (ch == pnmp_pkg::CH_SHARP);
        cls.is_flat   = (ch == pnmp_pkg::CH_FLAT);
        cls.is_plus   = (ch == pnmp_pkg::CH_PLUS);
        cls.is_minus  = (ch == pnmp_pkg::CH_MINUS);
        cls.is_digit  = (ch >= pnmp_pkg::CH_ZERO) && (ch <= pnmp_pkg::CH_NINE);
        cls.digit     = digit_diff[3:0];
        cls.is_letter = 1'b1;
        unique case (upper)
            pnmp_pkg::CH_UP_C: cls.pitch = 4'd0;
            pnmp_pkg::CH_UP_D: cls.pitch = 4'd2;
            pnmp_pkg::CH_UP_E: cls.pitch = 4'd4;
            pnmp_pkg::CH_UP_F: cls.pitch = 4'd5;
            pnmp_pkg::CH_UP_G: cls.pitch = 4'd7;
            pnmp_pkg::CH_UP_A: cls.pitch = 4'd9;
            pnmp_pkg::CH_UP_B: cls.pitch = 4'd11;
            default:
            begin
                cls.pitch     = 4'd0;
                cls.is_letter = 1'b0;
            end
        endcase
    end

    // an empty item that does not end the name changes nothing, so drop it here
    assign keep = !no_char || last;

endmodule

[rtl/pnmp_queue.sv]
// pnmp_queue: small register queue with push/full and pop/empty sides
// depends on pnmp_pkg for the default depth
module pnmp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pnmp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    // pointer and fill count
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/pnmp_parser.sv]
// pnmp_parser: back part, walks the note grammar one classified character per cycle
// unless stalled; depends on pnmp_pkg; hands the final parse state to pnmp_finish
module pnmp_parser #(
    parameter int OFFSET_WIDTH = pnmp_pkg::OFFSET_WIDTH_DEF,
    parameter int OCTAVE_WIDTH = pnmp_pkg::OCTAVE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  pnmp_pkg::char_class_t    item,
    output logic                     item_pop,
    input  logic                     fin_ready,
    output logic                     rec_load,
    output pnmp_pkg::phase_t         rec_phase,
    output logic [3:0]               rec_pitch,
    output logic [OFFSET_WIDTH-1:0]  rec_offset,
    output logic                     rec_negative,
    output logic [OCTAVE_WIDTH-1:0]  rec_octave,
    output pnmp_pkg::status_t        rec_error
);

    localparam int VW = OCTAVE_WIDTH + 4;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {1'b0, {(OFFSET_WIDTH - 1){1'b1}}};
    localparam logic [OFFSET_WIDTH-1:0] OFF_MIN = {1'b1, {(OFFSET_WIDTH - 1){1'b0}}};
    localparam logic [OCTAVE_WIDTH-1:0] OCT_MAX = '1;

    pnmp_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              pitch_reg, pitch_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic                    sharp_reg, sharp_next;
    logic                    flat_reg, flat_next;
    logic                    neg_reg, neg_next;
    logic [OCTAVE_WIDTH-1:0] oct_reg, oct_next;
    pnmp_pkg::status_t       err_reg, err_next;

    logic [VW-1:0]           oct_ext;
    logic [VW-1:0]           oct_times;
    logic [OCTAVE_WIDTH-1:0] oct_added;

    assign item_pop = item_valid && (!item.last || fin_ready);
    assign rec_load = item_pop && item.last;

    // decimal digit step with saturation
    always_comb
    begin
        oct_ext   = VW'(oct_reg);
        oct_times = (oct_ext << 3) + (oct_ext << 1) + VW'(item.digit);
        oct_added = (oct_times > VW'(OCT_MAX)) ? OCT_MAX : oct_times[OCTAVE_WIDTH-1:0];
    end

    // grammar step
    always_comb
    begin
        phase_next  = phase_reg;
        pitch_next  = pitch_reg;
        offset_next = offset_reg;
        sharp_next  = sharp_reg;
        flat_next   = flat_reg;
        neg_next    = neg_reg;
        oct_next    = oct_reg;
        err_next    = err_reg;
        if (!item.none)
        begin
            unique case (phase_reg)
                pnmp_pkg::PH_LETTER:
                begin
                    if (item.is_letter)
                    begin
                        pitch_next = item.pitch;
                        phase_next = pnmp_pkg::PH_ACC;
                    end
                    else
                    begin
                        err_next   = pnmp_pkg::ST_BAD_LETTER;
                        phase_next = pnmp_pkg::PH_ERROR;
                    end
                end
                pnmp_pkg::PH_ACC:
                begin
                    priority if (item.is_sharp || item.is_flat)
                    begin
                        if (item.is_sharp)
                        begin
                            sharp_next = 1'b1;
                            if (offset_reg != OFF_MAX)
                            begin
                                offset_next = offset_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            flat_next = 1'b1;
                            if (offset_reg != OFF_MIN)
                            begin
                                offset_next = offset_reg - 1'b1;
                            end
                        end
                        if ((sharp_reg || item.is_sharp) && (flat_reg || item.is_flat))
                        begin
                            err_next   = pnmp_pkg::ST_MIXED;
                            phase_next = pnmp_pkg::PH_ERROR;
                        end
                    end
                    else if (item.is_plus || item.is_minus)
                    begin
                        neg_next   = item.is_minus;
                        phase_next = pnmp_pkg::PH_SIGN;
                    end
                    else if (item.is_digit)
                    begin
                        oct_next   = oct_added;
                        phase_next = pnmp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        err_next   = pnmp_pkg::ST_BAD_OCTAVE;
                        phase_next = pnmp_pkg::PH_ERROR;
                    end
                end
                pnmp_pkg::PH_SIGN, pnmp_pkg::PH_DIGITS:
                begin
                    if (item.is_digit)
                    begin
                        oct_next   = oct_added;
                        phase_next = pnmp_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        err_next   = pnmp_pkg::ST_BAD_OCTAVE;
                        phase_next = pnmp_pkg::PH_ERROR;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // parse state at the end of the name
    assign rec_phase    = phase_next;
    assign rec_pitch    = pitch_next;
    assign rec_offset   = offset_next;
    assign rec_negative = neg_next;
    assign rec_octave   = oct_next;
    assign rec_error    = err_next;

    // state registers, cleared after each name
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pnmp_pkg::PH_LETTER;
            pitch_reg  <= '0;
            offset_reg <= '0;
            sharp_reg  <= 1'b0;
            flat_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            oct_reg    <= '0;
            err_reg    <= pnmp_pkg::ST_OK;
        end
        else if (item_pop)
        begin
            if (item.last)
            begin
                phase_reg  <= pnmp_pkg::PH_LETTER;
                pitch_reg  <= '0;
                offset_reg <= '0;
                sharp_reg  <= 1'b0;
                flat_reg   <= 1'b0;
                neg_reg    <= 1'b0;
                oct_reg    <= '0;
                err_reg    <= pnmp_pkg::ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                pitch_reg  <= pitch_next;
                offset_reg <= offset_next;
                sharp_reg  <= sharp_next;
                flat_reg   <= flat_next;
                neg_reg    <= neg_next;
                oct_reg    <= oct_next;
                err_reg    <= err_next;
            end
        end
    end

    // a finished name leaves a clean parse state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_load |=> (phase_reg == pnmp_pkg::PH_LETTER) && (err_reg == pnmp_pkg::ST_OK))
        else $error("parse state not cleared after last item");

    // both accidental kinds only ever coexist in the error phase
    a_mixed_is_error: assert property (@(posedge clk) disable iff (!rst_n)
        (sharp_reg && flat_reg) |-> (phase_reg == pnmp_pkg::PH_ERROR))
        else $error("mixed accidentals outside error phase");

    // waiting for a letter means nothing has been gathered yet
    a_letter_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pnmp_pkg::PH_LETTER)
        |-> (offset_reg == '0) && (oct_reg == '0) && !sharp_reg && !flat_reg && !neg_reg)
        else $error("stale state while expecting a letter");

endmodule

[rtl/pnmp_finish.sv]
// pnmp_finish: turns the final parse state into a midi note and status
// depends on pnmp_pkg; feeds the result queue
module pnmp_finish #(
    parameter int OFFSET_WIDTH = pnmp_pkg::OFFSET_WIDTH_DEF,
    parameter int OCTAVE_WIDTH = pnmp_pkg::OCTAVE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rec_load,
    input  pnmp_pkg::phase_t                  rec_phase,
    input  logic [3:0]                        rec_pitch,
    input  logic [OFFSET_WIDTH-1:0]           rec_offset,
    input  logic                              rec_negative,
    input  logic [OCTAVE_WIDTH-1:0]           rec_octave,
    input  pnmp_pkg::status_t                 rec_error,
    output logic                              fin_ready,
    output logic                              res_push,
    input  logic                              res_full,
    output logic [pnmp_pkg::MIDI_WIDTH-1:0]   res_note,
    output pnmp_pkg::status_t                 res_status
);

    localparam int MW = ((OCTAVE_WIDTH > OFFSET_WIDTH) ? OCTAVE_WIDTH : OFFSET_WIDTH) + 7;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {1'b0, {(OFFSET_WIDTH - 1){1'b1}}};
    localparam logic [OFFSET_WIDTH-1:0] OFF_MIN = {1'b1, {(OFFSET_WIDTH - 1){1'b0}}};
    localparam logic [OCTAVE_WIDTH-1:0] OCT_MAX = '1;
    localparam logic signed [MW-1:0] CENTER = MW'(pnmp_pkg::MIDI_CENTER);
    localparam logic signed [MW-1:0] TOP    = MW'(pnmp_pkg::MIDI_TOP);

    logic                    valid_reg, valid_next;
    pnmp_pkg::phase_t        phase_reg;
    logic [3:0]              pitch_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic                    neg_reg;
    logic [OCTAVE_WIDTH-1:0] oct_reg;
    pnmp_pkg::status_t       err_reg;

    logic signed [MW-1:0] off_s;
    logic signed [MW-1:0] pitch_s;
    logic signed [MW-1:0] oct_s;
    logic signed [MW-1:0] oct_plus;
    logic signed [MW-1:0] midi;
    logic                 sat;

    assign res_push  = valid_reg && !res_full;
    assign fin_ready = !valid_reg || !res_full;

    // held record
    always_comb
    begin
        valid_next = valid_reg;
        if (rec_load)
        begin
            valid_next = 1'b1;
        end
        else if (res_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_load)
        begin
            phase_reg  <= rec_phase;
            pitch_reg  <= rec_pitch;
            offset_reg <= rec_offset;
            neg_reg    <= rec_negative;
            oct_reg    <= rec_octave;
            err_reg    <= rec_error;
        end
    end

    // note arithmetic, times twelve as two shifts
    always_comb
    begin
        off_s    = MW'(signed'(offset_reg));
        pitch_s  = signed'(MW'(pitch_reg));
        oct_s    = signed'(MW'(oct_reg));
        if (neg_reg)
        begin
            oct_s = -oct_s;
        end
        oct_plus = oct_s + MW'(1);
        if (phase_reg == pnmp_pkg::PH_ACC)
        begin
            midi = CENTER + pitch_s + off_s;
        end
        else
        begin
            midi = (oct_plus <<< 3) + (oct_plus <<< 2) + pitch_s + off_s;
        end
    end

    // status
    always_comb
    begin
        sat        = (offset_reg == OFF_MAX) || (offset_reg == OFF_MIN);
        res_note   = '0;
        res_status = pnmp_pkg::ST_OK;
        unique case (phase_reg)
            pnmp_pkg::PH_ERROR:  res_status = err_reg;
            pnmp_pkg::PH_LETTER: res_status = pnmp_pkg::ST_EMPTY;
            pnmp_pkg::PH_SIGN:   res_status = pnmp_pkg::ST_BAD_OCTAVE;
            pnmp_pkg::PH_ACC, pnmp_pkg::PH_DIGITS:
            begin
                if ((phase_reg == pnmp_pkg::PH_DIGITS) && (oct_reg == OCT_MAX))
                begin
                    sat = 1'b1;
                end
                if (sat || midi < 0 || midi > TOP)
                begin
                    res_status = pnmp_pkg::ST_RANGE;
                end
                else
                begin
                    res_note = midi[pnmp_pkg::MIDI_WIDTH-1:0];
                end
            end
            default: res_status = err_reg;
        endcase
    end

endmodule

[rtl/pitch_name_to_midi_parser.sv]
// pitch_name_to_midi_parser: the last character passes the character queue, the parser step
// into the finish stage register and the result queue before empty goes low; one character
// accepted per cycle sustained while full is low, set by the grammar step in the parser
// asynchronous active-low reset empties both queues and returns the parse to expect letter
// top level; depends on pnmp_pkg, pnmp_front, pnmp_queue, pnmp_parser, pnmp_finish
module pitch_name_to_midi_parser #(
    parameter int OFFSET_WIDTH = pnmp_pkg::OFFSET_WIDTH_DEF,
    parameter int OCTAVE_WIDTH = pnmp_pkg::OCTAVE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      ch,
    input  logic                            last,
    input  logic                            no_char,
    output logic                            empty,
    input  logic                            pop,
    output logic [pnmp_pkg::MIDI_WIDTH-1:0] midi_note,
    output logic [pnmp_pkg::STATUS_WIDTH-1:0] status
);

    localparam int CW = $bits(pnmp_pkg::char_class_t);
    localparam int RW = pnmp_pkg::MIDI_WIDTH + pnmp_pkg::STATUS_WIDTH;

    pnmp_pkg::char_class_t   front_cls;
    logic                    front_keep;
    logic [CW-1:0]           cls_q;
    logic                    cls_empty;
    logic                    item_pop;
    logic                    rec_load;
    pnmp_pkg::phase_t        rec_phase;
    logic [3:0]              rec_pitch;
    logic [OFFSET_WIDTH-1:0] rec_offset;
    logic                    rec_negative;
    logic [OCTAVE_WIDTH-1:0] rec_octave;
    pnmp_pkg::status_t       rec_error;
    logic                    fin_ready;
    logic                    res_push;
    logic                    res_full;
    logic [pnmp_pkg::MIDI_WIDTH-1:0] res_note;
    pnmp_pkg::status_t       res_status;
    logic [RW-1:0]           res_q;

    // front: classify characters
    pnmp_front u_front (
        .ch      (ch),
        .last    (last),
        .no_char (no_char),
        .cls     (front_cls),
        .keep    (front_keep)
    );

    // queue between front and back
    pnmp_queue #(
        .WIDTH (CW),
        .DEPTH (pnmp_pkg::QUEUE_DEPTH)
    ) u_cls_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && front_keep),
        .wdata (front_cls),
        .full  (full),
        .pop   (item_pop),
        .rdata (cls_q),
        .empty (cls_empty)
    );

    // back: grammar walk
    pnmp_parser #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .OCTAVE_WIDTH (OCTAVE_WIDTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (!cls_empty),
        .item         (pnmp_pkg::char_class_t'(cls_q)),
        .item_pop     (item_pop),
        .fin_ready    (fin_ready),
        .rec_load     (rec_load),
        .rec_phase    (rec_phase),
        .rec_pitch    (rec_pitch),
        .rec_offset   (rec_offset),
        .rec_negative (rec_negative),
        .rec_octave   (rec_octave),
        .rec_error    (rec_error)
    );

    // back: note arithmetic and status
    pnmp_finish #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .OCTAVE_WIDTH (OCTAVE_WIDTH)
    ) u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_load     (rec_load),
        .rec_phase    (rec_phase),
        .rec_pitch    (rec_pitch),
        .rec_offset   (rec_offset),
        .rec_negative (rec_negative),
        .rec_octave   (rec_octave),
        .rec_error    (rec_error),
        .fin_ready    (fin_ready),
        .res_push     (res_push),
        .res_full     (res_full),
        .res_note     (res_note),
        .res_status   (res_status)
    );

    // result queue toward the consumer
    pnmp_queue #(
        .WIDTH (RW),
        .DEPTH (pnmp_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({res_note, res_status}),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_q),
        .empty (empty)
    );

    assign midi_note = res_q[RW-1:pnmp_pkg::STATUS_WIDTH];
    assign status    = res_q[pnmp_pkg::STATUS_WIDTH-1:0];

endmodule

[bench/pitch_name_to_midi_parser_tb.sv]
// pitch_name_to_midi_parser_tb: self-checking bench for the note name to MIDI number parser
// drives characters through the push/full queue side and checks pop/empty results in order
// depends on pnmp_pkg and the pitch_name_to_midi_parser top level
module pitch_name_to_midi_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD   = 20;
    localparam int     OFF_W        = 12;
    localparam int     OCT_W        = 10;
    localparam int     OFF_MAX      = (1 << (OFF_W - 1)) - 1;
    localparam int     OFF_MIN      = -(1 << (OFF_W - 1));
    localparam longint OCT_MAX      = (longint'(1) << OCT_W) - 1;
    localparam int     SEMITONES    = 12;
    localparam int     RANDOM_ITEMS = 1430;
    localparam int     LONG_RUN     = 40;
    localparam int     DRAIN_LIMIT  = 2000;
    localparam int     TAIL_CYCLES  = 8;

    typedef logic [7:0] char_q_t[$];

    typedef struct packed {
        logic [pnmp_pkg::MIDI_WIDTH-1:0] midi;
        pnmp_pkg::status_t               st;
    } note_result_t;

    // clock and block ports
    logic                              clk     = 1'b0;
    logic                              rst_n   = 1'b0;
    logic                              push    = 1'b0;
    logic                              full;
    logic [7:0]                        ch      = 8'h00;
    logic                              last    = 1'b0;
    logic                              no_char = 1'b0;
    logic                              empty;
    logic                              pop     = 1'b0;
    logic [pnmp_pkg::MIDI_WIDTH-1:0]   midi_note;
    logic [pnmp_pkg::STATUS_WIDTH-1:0] status;

    // shared bench state
    note_result_t expected_notes[$];
    bit           no_gaps         = 1'b0;
    int           errors          = 0;
    int           chars_sent      = 0;
    int           names_sent      = 0;
    int           results_checked = 0;

    // parse state of the predictor
    pnmp_pkg::phase_t  parse_phase = pnmp_pkg::PH_LETTER;
    int                cur_pitch   = 0;
    int                acc_count   = 0;
    bit                sharp_seen  = 1'b0;
    bit                flat_seen   = 1'b0;
    bit                oct_minus   = 1'b0;
    longint            oct_count   = 0;
    pnmp_pkg::status_t first_err   = pnmp_pkg::ST_OK;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pitch_name_to_midi_parser #(
        .OFFSET_WIDTH(OFF_W),
        .OCTAVE_WIDTH(OCT_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .ch       (ch),
        .last     (last),
        .no_char  (no_char),
        .empty    (empty),
        .pop      (pop),
        .midi_note(midi_note),
        .status   (status)
    );

    // ---------------------------------------------------------------- predictor

    task automatic clear_name_state();
        parse_phase = pnmp_pkg::PH_LETTER;
        cur_pitch   = 0;
        acc_count   = 0;
        sharp_seen  = 1'b0;
        flat_seen   = 1'b0;
        oct_minus   = 1'b0;
        oct_count   = 0;
        first_err   = pnmp_pkg::ST_OK;
    endtask

    // semitone of a note letter, -1 for anything else
    function automatic int letter_pitch(logic [7:0] c);
        logic [7:0] u;
        u = (c >= pnmp_pkg::CH_LOW_A && c <= pnmp_pkg::CH_LOW_Z) ? c - pnmp_pkg::CASE_GAP : c;
        case (u)
            pnmp_pkg::CH_UP_C: return 0;
            pnmp_pkg::CH_UP_D: return 2;
            pnmp_pkg::CH_UP_E: return 4;
            pnmp_pkg::CH_UP_F: return 5;
            pnmp_pkg::CH_UP_G: return 7;
            pnmp_pkg::CH_UP_A: return 9;
            pnmp_pkg::CH_UP_B: return 11;
            default: return -1;
        endcase
    endfunction

    task automatic name_error(pnmp_pkg::status_t code);
        first_err   = code;
        parse_phase = pnmp_pkg::PH_ERROR;
    endtask

    // decimal accumulate, holding at the top value
    task automatic add_digit(logic [7:0] c);
        longint v;
        v = oct_count * 10 + longint'(c - pnmp_pkg::CH_ZERO);
        oct_count = (v > OCT_MAX) ? OCT_MAX : v;
    endtask

    task automatic take_char(logic [7:0] c);
        bit is_digit;
        int p;
        is_digit = (c >= pnmp_pkg::CH_ZERO && c <= pnmp_pkg::CH_NINE);
        case (parse_phase)
            pnmp_pkg::PH_LETTER:
            begin
                p = letter_pitch(c);
                if (p < 0)
                begin
                    name_error(pnmp_pkg::ST_BAD_LETTER);
                end
                else
                begin
                    cur_pitch   = p;
                    parse_phase = pnmp_pkg::PH_ACC;
                end
            end
            pnmp_pkg::PH_ACC:
            begin
                if (c == pnmp_pkg::CH_SHARP || c == pnmp_pkg::CH_FLAT)
                begin
                    if (c == pnmp_pkg::CH_SHARP)
                    begin
                        sharp_seen = 1'b1;
                        if (acc_count < OFF_MAX) acc_count++;
                    end
                    else
                    begin
                        flat_seen = 1'b1;
                        if (acc_count > OFF_MIN) acc_count--;
                    end
                    if (sharp_seen && flat_seen) name_error(pnmp_pkg::ST_MIXED);
                end
                else if (c == pnmp_pkg::CH_PLUS || c == pnmp_pkg::CH_MINUS)
                begin
                    oct_minus   = (c == pnmp_pkg::CH_MINUS);
                    parse_phase = pnmp_pkg::PH_SIGN;
                end
                else if (is_digit)
                begin
                    add_digit(c);
                    parse_phase = pnmp_pkg::PH_DIGITS;
                end
                else
                begin
                    name_error(pnmp_pkg::ST_BAD_OCTAVE);
                end
            end
            pnmp_pkg::PH_SIGN:
            begin
                if (is_digit)
                begin
                    add_digit(c);
                    parse_phase = pnmp_pkg::PH_DIGITS;
                end
                else
                begin
                    name_error(pnmp_pkg::ST_BAD_OCTAVE);
                end
            end
            pnmp_pkg::PH_DIGITS:
            begin
                if (is_digit) add_digit(c);
                else name_error(pnmp_pkg::ST_BAD_OCTAVE);
            end
            default: ;
        endcase
    endtask

    // result of the name parsed so far
    task automatic close_name(output note_result_t r);
        longint midi;
        longint oct;
        bit     sat;
        sat    = (acc_count == OFF_MAX) || (acc_count == OFF_MIN);
        r.midi = '0;
        r.st   = pnmp_pkg::ST_OK;
        midi   = 0;
        case (parse_phase)
            pnmp_pkg::PH_ERROR:
            begin
                r.st = first_err;
                return;
            end
            pnmp_pkg::PH_LETTER:
            begin
                r.st = pnmp_pkg::ST_EMPTY;
                return;
            end
            pnmp_pkg::PH_SIGN:
            begin
                r.st = pnmp_pkg::ST_BAD_OCTAVE;
                return;
            end
            pnmp_pkg::PH_ACC:
            begin
                midi = pnmp_pkg::MIDI_CENTER + cur_pitch + acc_count;
            end
            default:
            begin
                oct = oct_count;
                if (oct_count == OCT_MAX) sat = 1'b1;
                if (oct_minus) oct = -oct;
                midi = (oct + 1) * SEMITONES + cur_pitch + acc_count;
            end
        endcase
        if (sat || midi < 0 || midi > pnmp_pkg::MIDI_TOP) r.st = pnmp_pkg::ST_RANGE;
        else r.midi = midi[pnmp_pkg::MIDI_WIDTH-1:0];
    endtask

    task automatic predict_item(logic [7:0] c, logic is_last, logic is_none);
        note_result_t r;
        if (!is_none) take_char(c);
        if (is_last)
        begin
            close_name(r);
            expected_notes.push_back(r);
            clear_name_state();
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // one input transaction; push stays high afterwards so back-to-back items keep streaming
    task automatic send_item(logic [7:0] c, logic is_last, logic is_none);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        ch      <= c;
        last    <= is_last;
        no_char <= is_none;
        do @(posedge clk); while (full);
        predict_item(c, is_last, is_none);
        chars_sent++;
        if (is_last) names_sent++;
    endtask

    // a whole name, optionally ended by a no-character item and sprinkled with ignored items
    task automatic send_name(char_q_t text, bit none_end, bit sprinkle);
        for (int i = 0; i < text.size(); i++)
        begin
            if (sprinkle && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(text[i], !none_end && (i == text.size() - 1), 1'b0);
        end
        if (none_end) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic send_str(string s, bit none_end);
        char_q_t text;
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_name(text, none_end, 1'b0);
    endtask

    // ---------------------------------------------------------------- result checker

    initial
    begin : result_checker
        int           stall;
        note_result_t exp_note;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            results_checked++;
            if (expected_notes.size() == 0)
            begin
                $error("unexpected result: midi_note %0d status %0d", midi_note, status);
                errors++;
            end
            else
            begin
                exp_note = expected_notes.pop_front();
                if (midi_note !== exp_note.midi)
                begin
                    $error("midi_note mismatch: expected %0d, actual %0d",
                           exp_note.midi, midi_note);
                    errors++;
                end
                if (status !== exp_note.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", exp_note.st, status);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // empty names and items that carry no character
    task automatic test_empty_name();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h47, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'h39, 1'b1, 1'b0);
    endtask

    // each grammar path and every error code but the empty one
    task automatic test_grammar_cases();
        send_str("g#9", 1'b0);
        send_str("Cb-1", 1'b0);
        send_str("C-1", 1'b0);
        send_str("a+", 1'b0);
        send_str("H#", 1'b0);
        send_str("Eb#", 1'b0);
        send_str("F4x", 1'b0);
        send_str("B", 1'b1);
        send_str("d1023", 1'b0);
        send_str("e", 1'b0);
    endtask

    // long runs of one accidental kind at full rate
    task automatic test_long_accidentals();
        char_q_t text;
        no_gaps = 1'b1;
        text.push_back(pnmp_pkg::CH_UP_C);
        repeat (LONG_RUN) text.push_back(pnmp_pkg::CH_SHARP);
        send_name(text, 1'b0, 1'b0);
        text = {};
        text.push_back(pnmp_pkg::CH_LOW_A);
        repeat (LONG_RUN + 1) text.push_back(pnmp_pkg::CH_FLAT);
        send_name(text, 1'b1, 1'b0);
        no_gaps = 1'b0;
    endtask

    // mostly well-formed names with random content, plus noise and corrupted names
    task automatic make_random_name(output char_q_t text, output bit none_end);
        string      letter_set;
        int         kind;
        int         n_acc;
        int         n_dig;
        int         mode;
        int         pick;
        logic [7:0] acc_ch;
        letter_set = "CDEFGABcdefgab";
        text       = {};
        kind       = $urandom_range(0, 9);
        none_end   = ($urandom_range(0, 4) == 0);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        text.push_back(letter_set[$urandom_range(0, 13)]);
        // accidentals, rarely mixed
        n_acc  = $urandom_range(0, 3);
        acc_ch = $urandom_range(0, 1) ? pnmp_pkg::CH_SHARP : pnmp_pkg::CH_FLAT;
        repeat (n_acc) text.push_back(acc_ch);
        if ($urandom_range(0, 9) == 0)
            text.push_back(acc_ch == pnmp_pkg::CH_SHARP ? pnmp_pkg::CH_FLAT : pnmp_pkg::CH_SHARP);
        // octave: none, bare digits, or signed digits
        mode = $urandom_range(0, 3);
        if (mode != 0)
        begin
            if (mode == 2) text.push_back(pnmp_pkg::CH_PLUS);
            if (mode == 3) text.push_back(pnmp_pkg::CH_MINUS);
            pick = $urandom_range(0, 9);
            if (pick == 0) n_dig = (mode == 1) ? 1 : 0;
            else if (pick <= 6) n_dig = 1;
            else if (pick <= 8) n_dig = 2;
            else n_dig = $urandom_range(3, 4);
            repeat (n_dig) text.push_back(pnmp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        // corrupt one position
        if (kind == 1)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic test_random_names();
        char_q_t text;
        bit      none_end;
        int      target;
        int      idx;
        target = chars_sent + RANDOM_ITEMS;
        idx    = 0;
        while (chars_sent < target)
        begin
            // switch between idling and full-rate stretches
            if (idx % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            make_random_name(text, none_end);
            send_name(text, none_end, 1'b1);
            idx++;
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin : main_sequence
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_name();
        test_grammar_cases();
        test_long_accidentals();
        test_random_names();
        push <= 1'b0;

        // drain outstanding results, then watch for extra ones
        waited = 0;
        while (expected_notes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_notes.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_notes.size());
            errors++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d input transactions in %0d names, %0d results checked",
                 chars_sent, names_sent, results_checked);
        $display("including empty names, every error code and long accidental runs");
        if (errors == 0)
        begin
            $display("PASS pitch_name_to_midi_parser");
        end
        else
        begin
            $display("FAIL pitch_name_to_midi_parser");
        end
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #20_000_000;
        $display("FAIL pitch_name_to_midi_parser");
        $finish;
    end

endmodule
